FILE: sv/gba_pkg.sv
// shared types, codes and defaults for the grouped bitmap id allocator
package gba_pkg;

    localparam int NUM_IDS_DEF = 128;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int START_W    = 7;
    localparam int COUNT_W    = 8;
    localparam int NUMBER_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int GRANT_W    = 7;

    localparam logic [CFG_IDX_W-1:0] REG_GROUP_ONE_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_TWO_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_TWO_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_THREE_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_THREE_COUNT = 3'd4;

    localparam logic [COUNT_W-1:0] GROUP_ONE_COUNT_RST   = 8'd32;
    localparam logic [START_W-1:0] GROUP_TWO_START_RST   = 7'd32;
    localparam logic [COUNT_W-1:0] GROUP_TWO_COUNT_RST   = 8'd48;
    localparam logic [START_W-1:0] GROUP_THREE_START_RST = 7'd80;
    localparam logic [COUNT_W-1:0] GROUP_THREE_COUNT_RST = 8'd48;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] group_one_count;
        logic [START_W-1:0] group_two_start;
        logic [COUNT_W-1:0] group_two_count;
        logic [START_W-1:0] group_three_start;
        logic [COUNT_W-1:0] group_three_count;
    } grp_cfg_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
    } map_ctl_t;

endpackage

FILE: sv/grouped_bitmap_id_allocator_top.sv
// top level: configuration registers, sequencer and usage map
//
// After reset the block sweeps the usage map clear, one id per clock, and busy
// stays high until the whole map is clear. An item is taken when start is high
// and busy is low. A release is handled in the idle state: done pulses on the
// next cycle and busy never rises. An allocate walks the three ranges in
// priority order through the single map read port, one id per cycle; each
// range starts with a load step before its scan, and a free id near the bottom
// of range one is found soonest. done is a single-cycle strobe with status and
// granted_number; it cannot be held off, so the user must capture it. busy
// drops in the same cycle as done.
module grouped_bitmap_id_allocator_top
    import gba_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [NUMBER_W-1:0]   release_number,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [GRANT_W-1:0]    granted_number,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

    logic [COUNT_W-1:0] group_one_count_reg;
    logic [START_W-1:0] group_two_start_reg;
    logic [COUNT_W-1:0] group_two_count_reg;
    logic [START_W-1:0] group_three_start_reg;
    logic [COUNT_W-1:0] group_three_count_reg;

    grp_cfg_t      cfg;
    map_ctl_t      ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          rd_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_one_count_reg   <= GROUP_ONE_COUNT_RST;
            group_two_start_reg   <= GROUP_TWO_START_RST;
            group_two_count_reg   <= GROUP_TWO_COUNT_RST;
            group_three_start_reg <= GROUP_THREE_START_RST;
            group_three_count_reg <= GROUP_THREE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GROUP_ONE_COUNT:   group_one_count_reg   <= cfg_data;
                REG_GROUP_TWO_START:   group_two_start_reg   <= cfg_data[START_W-1:0];
                REG_GROUP_TWO_COUNT:   group_two_count_reg   <= cfg_data;
                REG_GROUP_THREE_START: group_three_start_reg <= cfg_data[START_W-1:0];
                REG_GROUP_THREE_COUNT: group_three_count_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.group_one_count   = group_one_count_reg;
    assign cfg.group_two_start   = group_two_start_reg;
    assign cfg.group_two_count   = group_two_count_reg;
    assign cfg.group_three_start = group_three_start_reg;
    assign cfg.group_three_count = group_three_count_reg;

    gba_seq #(
        .NUM_IDS (NUM_IDS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .func           (func),
        .release_number (release_number),
        .cfg            (cfg),
        .rd_bit         (rd_bit),
        .ctl            (ctl),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .granted_number (granted_number)
    );

    gba_map #(
        .NUM_IDS (NUM_IDS)
    ) u_map (
        .clk     (clk),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .rd_bit  (rd_bit)
    );

endmodule

FILE: sv/gba_map.sv
// one-bit-per-id usage map memory with one write and one registered read port
module gba_map
    import gba_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF,
    localparam int AW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1
)
(
    input  logic           clk,
    input  map_ctl_t       ctl,
    input  logic [AW-1:0]  rd_addr,
    input  logic [AW-1:0]  wr_addr,
    output logic           rd_bit
);

    logic mem [NUM_IDS];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= ctl.wr_bit;
        end
        if (ctl.rd_en)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

FILE: sv/gba_seq.sv
// sequencer: map clear, release, and one-id-per-cycle range scan for allocate
module gba_seq
    import gba_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF,
    localparam int AW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1,
    localparam int SPAN_W = ($clog2(NUM_IDS) + 1 > 9) ? $clog2(NUM_IDS) + 1 : 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 func,
    input  logic [NUMBER_W-1:0]  release_number,
    input  grp_cfg_t             cfg,
    input  logic                 rd_bit,
    output map_ctl_t             ctl,
    output logic [AW-1:0]        rd_addr,
    output logic [AW-1:0]        wr_addr,
    output logic                 busy,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [GRANT_W-1:0]   granted_number
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    localparam logic [1:0] GRP_ONE   = 2'd0;
    localparam logic [1:0] GRP_TWO   = 2'd1;
    localparam logic [1:0] GRP_THREE = 2'd2;

    localparam logic [SPAN_W-1:0] NUM_EXT  = SPAN_W'(NUM_IDS);
    localparam logic [SPAN_W-1:0] LAST_EXT = SPAN_W'(NUM_IDS - 1);

    logic [1:0]          state_reg, state_next;
    logic [1:0]          grp_reg, grp_next;
    logic [SPAN_W-1:0]   idx_reg, idx_next;
    logic [SPAN_W-1:0]   end_reg, end_next;
    logic                probe_vld_reg, probe_vld_next;
    logic [SPAN_W-1:0]   probe_idx_reg, probe_idx_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [GRANT_W-1:0]  granted_reg, granted_next;

    logic [START_W-1:0]  start_sel;
    logic [COUNT_W-1:0]  count_sel;
    logic [SPAN_W-1:0]   span_sum;
    logic [SPAN_W-1:0]   span_lim;
    logic [SPAN_W-1:0]   rel_ext;
    logic                found;

    always_comb
    begin
        unique case (grp_reg)
            GRP_ONE:
            begin
                start_sel = '0;
                count_sel = cfg.group_one_count;
            end
            GRP_TWO:
            begin
                start_sel = cfg.group_two_start;
                count_sel = cfg.group_two_count;
            end
            GRP_THREE:
            begin
                start_sel = cfg.group_three_start;
                count_sel = cfg.group_three_count;
            end
            default:
            begin
                start_sel = '0;
                count_sel = '0;
            end
        endcase
    end

    // range end, clipped to the map size
    assign span_sum = SPAN_W'(start_sel) + SPAN_W'(count_sel);
    assign span_lim = (span_sum > NUM_EXT) ? NUM_EXT : span_sum;
    assign rel_ext  = SPAN_W'(release_number);
    assign found    = probe_vld_reg && !rd_bit;

    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        probe_vld_next = probe_vld_reg;
        probe_idx_next = probe_idx_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        granted_next   = granted_reg;
        ctl            = '0;
        rd_addr        = idx_reg[AW-1:0];
        wr_addr        = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_bit = 1'b0;
                if (idx_reg == LAST_EXT)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SPAN_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_RELEASE)
                    begin
                        done_next    = 1'b1;
                        granted_next = '0;
                        if (rel_ext >= NUM_EXT)
                        begin
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wr_bit  = 1'b0;
                            wr_addr     = rel_ext[AW-1:0];
                            status_next = STATUS_OK;
                        end
                    end
                    else
                    begin
                        grp_next   = GRP_ONE;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                idx_next       = SPAN_W'(start_sel);
                end_next       = span_lim;
                probe_vld_next = 1'b0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    ctl.wr_en      = 1'b1;
                    ctl.wr_bit     = 1'b1;
                    wr_addr        = probe_idx_reg[AW-1:0];
                    done_next      = 1'b1;
                    status_next    = STATUS_OK;
                    granted_next   = probe_idx_reg[GRANT_W-1:0];
                    probe_vld_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else if (idx_reg < end_reg)
                begin
                    ctl.rd_en      = 1'b1;
                    rd_addr        = idx_reg[AW-1:0];
                    probe_vld_next = 1'b1;
                    probe_idx_next = idx_reg;
                    idx_next       = idx_reg + SPAN_W'(1);
                end
                else
                begin
                    probe_vld_next = 1'b0;
                    unique case (grp_reg)
                        GRP_ONE:
                        begin
                            grp_next   = GRP_TWO;
                            state_next = ST_LOAD;
                        end
                        GRP_TWO:
                        begin
                            grp_next   = GRP_THREE;
                            state_next = ST_LOAD;
                        end
                        default:
                        begin
                            done_next    = 1'b1;
                            status_next  = STATUS_EXHAUSTED;
                            granted_next = '0;
                            state_next   = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            grp_reg       <= GRP_ONE;
            idx_reg       <= '0;
            probe_vld_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grp_reg       <= grp_next;
            idx_reg       <= idx_next;
            probe_vld_reg <= probe_vld_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg       <= end_next;
        probe_idx_reg <= probe_idx_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_number = granted_reg;

endmodule
